>>> hw/rtl/bilinear_noise_perturb_top_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the bilinear noise perturb block.
// Clocked on clk_i and disabled while rst_ni is low.
// ------------------------------------------------------------------------
`ifndef BILINEAR_NOISE_PERTURB_TOP_ASSERT_SVH
`define BILINEAR_NOISE_PERTURB_TOP_ASSERT_SVH

// Same-cycle implication.
`define BNP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bilinear_noise_perturb assertion failed");

// Next-cycle implication.
`define BNP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bilinear_noise_perturb assertion failed");

`endif

>>> hw/rtl/bnp_pkg.sv
// ------------------------------------------------------------------------
// bnp_pkg
// Shared types and constants of the bilinear noise perturb block.
// ------------------------------------------------------------------------
package bnp_pkg;

  localparam int ADDR_W     = 16;
  localparam int TEXEL_W    = 32;
  localparam int CH_W       = 16;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SIDE_CFG_W = 9;
  localparam int SCALE_W    = 16;
  localparam int STR_W      = 20;

  // Opcodes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERTURB_STR   = 3'd4;

  // ceil(2^33 / 255): exact floor division by 255 for inputs below 2^25.
  localparam int          RECIP_SHIFT = 33;
  localparam logic [25:0] RECIP_255   = 26'd33686019;

  localparam logic [CH_W-1:0] CH_NEUTRAL = 16'h8000;

  // Texel store write port.
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [TEXEL_W-1:0] data;
  } texmem_wr_t;

endpackage

>>> hw/rtl/bnp_texmem.sv
// ------------------------------------------------------------------------
// bnp_texmem
// Texel store copy with one write port and two registered read ports.
// ------------------------------------------------------------------------
module bnp_texmem (
  input  logic                                 clk_i,
  input  bnp_pkg::texmem_wr_t                  wr_i,
  input  logic [bnp_pkg::ADDR_W-1:0]           rd_addr_a_i,
  input  logic [bnp_pkg::ADDR_W-1:0]           rd_addr_b_i,
  output logic [bnp_pkg::TEXEL_W-1:0]          rd_data_a_o,
  output logic [bnp_pkg::TEXEL_W-1:0]          rd_data_b_o
);

  logic [bnp_pkg::TEXEL_W-1:0] mem [2**bnp_pkg::ADDR_W];
  logic [bnp_pkg::TEXEL_W-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[rd_addr_a_i];
    rd_b_q <= mem[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

>>> hw/rtl/bilinear_noise_perturb_top.sv
// ------------------------------------------------------------------------
// bilinear_noise_perturb_top
// Bilinear wrap-around noise texture sampler that displaces 2-D positions.
// ------------------------------------------------------------------------
// How to use this block:
// An item is accepted on a rising edge with start_i high and busy_o low.
// A write item (opcode 0) stores texel_rgba_i at texel_index_i and gives
// no result. A sample item (opcode 1) gives one result: four blended
// channels in Q0.16 and the displaced position, shown on the result ports
// for exactly one cycle while result_valid_o is high.
// The block is a ten-stage pipeline and takes one item every cycle while
// busy_o is low. Four texels per cycle come from two copies of the
// texel store, each with two read ports; texel writes travel down the
// pipeline and reach the store in the stage where samples read it, so
// items keep their order.
// The receiver cannot stall, so nothing in the pipeline ever waits.
// Reset clears the valid bits and loads the register defaults; busy_o is
// high for the first cycle after reset. The texel store is not cleared.
// The user must write registers through cfg_we_i, cfg_idx_i and cfg_data_i
// only while no item is in flight; the block does not enforce this.
// ------------------------------------------------------------------------
module bilinear_noise_perturb_top #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic                                    opcode_i,
  input  logic [bnp_pkg::ADDR_W-1:0]              texel_index_i,
  input  logic [bnp_pkg::TEXEL_W-1:0]             texel_rgba_i,
  input  logic signed [bnp_pkg::POS_W-1:0]        pos_x_i,
  input  logic signed [bnp_pkg::POS_W-1:0]        pos_y_i,
  input  logic                                    cfg_we_i,
  input  logic [bnp_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [bnp_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  output logic                                    result_valid_o,
  output logic [bnp_pkg::CH_W-1:0]                noise_r_o,
  output logic [bnp_pkg::CH_W-1:0]                noise_g_o,
  output logic [bnp_pkg::CH_W-1:0]                noise_b_o,
  output logic [bnp_pkg::CH_W-1:0]                noise_a_o,
  output logic signed [bnp_pkg::POS_W-1:0]        moved_x_o,
  output logic signed [bnp_pkg::POS_W-1:0]        moved_y_o
);

  `include "bilinear_noise_perturb_top_assert.svh"

  localparam int FB    = FRAC_BITS;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int IDX_W = $clog2(MAX_SIDE);
  localparam int T_W   = FB + IDX_W;
  localparam int H_W   = FB + 8;
  localparam int V_W   = 2 * FB + 8;
  localparam int N_W   = 25;
  localparam int Q_W   = N_W + 26;
  localparam int PR_W  = 39;
  localparam int LAT   = 10;
  localparam int WR_LAT = 4;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  // ---------------- Configuration registers ----------------
  logic                               present_q;
  logic [bnp_pkg::SIDE_CFG_W-1:0]     width_q, height_q;
  logic [bnp_pkg::SCALE_W-1:0]        scale_q;
  logic [bnp_pkg::STR_W-1:0]          str_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      width_q   <= 9'd256;
      height_q  <= 9'd256;
      scale_q   <= 16'd655;
      str_q     <= 20'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bnp_pkg::CFG_NOISE_PRESENT: present_q <= cfg_data_i[0];
        bnp_pkg::CFG_TEX_WIDTH:     width_q   <= cfg_data_i[bnp_pkg::SIDE_CFG_W-1:0];
        bnp_pkg::CFG_TEX_HEIGHT:    height_q  <= cfg_data_i[bnp_pkg::SIDE_CFG_W-1:0];
        bnp_pkg::CFG_NOISE_SCALE:   scale_q   <= cfg_data_i[bnp_pkg::SCALE_W-1:0];
        bnp_pkg::CFG_PERTURB_STR:   str_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sides clamped to 1..MAX_SIDE.
  logic [SW-1:0]    w_side, h_side;
  logic [IDX_W-1:0] w_m1, h_m1;

  always_comb begin
    if (width_q == '0) w_side = SW'(1);
    else if (32'(width_q) > MAX_SIDE) w_side = SW'(MAX_SIDE);
    else w_side = SW'(width_q);
    if (height_q == '0) h_side = SW'(1);
    else if (32'(height_q) > MAX_SIDE) h_side = SW'(MAX_SIDE);
    else h_side = SW'(height_q);
    w_m1 = IDX_W'(w_side - SW'(1));
    h_m1 = IDX_W'(h_side - SW'(1));
  end

  // One cycle of busy after reset.
  logic busy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= 1'b1;
    else         busy_q <= 1'b0;
  end
  assign busy_o = busy_q;

  logic accept;
  assign accept = start_i && !busy_q;

  // Valid bits: sample valid per stage and write valid for stages 0..3.
  logic [8:0] sv_q;
  logic [3:0] wv_q;
  logic [6:0] pres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      wv_q <= '0;
    end else begin
      sv_q <= {sv_q[7:0], accept && (opcode_i == bnp_pkg::OP_SAMPLE)};
      wv_q <= {wv_q[2:0], accept && (opcode_i == bnp_pkg::OP_WRITE)};
    end
  end

  always_ff @(posedge clk_i) begin
    pres_q <= {pres_q[5:0], present_q};
  end

  // Position carried alongside the samples.
  logic signed [bnp_pkg::POS_W-1:0] px_q [9], py_q [9];
  always_ff @(posedge clk_i) begin
    px_q[0] <= pos_x_i;
    py_q[0] <= pos_y_i;
    for (int s = 1; s < 9; s++) begin
      px_q[s] <= px_q[s-1];
      py_q[s] <= py_q[s-1];
    end
  end

  // Write items carried to the store stage.
  logic [bnp_pkg::ADDR_W-1:0]  widx_q  [4];
  logic [bnp_pkg::TEXEL_W-1:0] wdata_q [4];
  always_ff @(posedge clk_i) begin
    widx_q[0]  <= texel_index_i;
    wdata_q[0] <= texel_rgba_i;
    for (int s = 1; s < 4; s++) begin
      widx_q[s]  <= widx_q[s-1];
      wdata_q[s] <= wdata_q[s-1];
    end
  end

  // ---------------- Stage 1: wrapped fraction ----------------
  logic signed [48:0] sx_prod, sy_prod;
  logic [FB-1:0]      ux_q, uy_q;

  assign sx_prod = px_q[0] * $signed({1'b0, scale_q});
  assign sy_prod = py_q[0] * $signed({1'b0, scale_q});

  always_ff @(posedge clk_i) begin
    ux_q <= sx_prod[31 -: FB];
    uy_q <= sy_prod[31 -: FB];
  end

  // ---------------- Stage 2: map onto the texture ----------------
  logic [T_W-1:0] tx_q, ty_q;
  always_ff @(posedge clk_i) begin
    tx_q <= T_W'(ux_q) * T_W'(w_m1);
    ty_q <= T_W'(uy_q) * T_W'(h_m1);
  end

  // ---------------- Stage 3: neighbor addresses ----------------
  logic [IDX_W-1:0] x0, y0, x1, y1;
  logic [SW-1:0]    x0p1, y0p1;
  logic [bnp_pkg::ADDR_W-1:0] a00_q, a10_q, a01_q, a11_q;
  logic [FB-1:0]    fx3_q, fy3_q;

  always_comb begin
    x0   = tx_q[FB +: IDX_W];
    y0   = ty_q[FB +: IDX_W];
    x0p1 = SW'(x0) + SW'(1);
    y0p1 = SW'(y0) + SW'(1);
    x1   = (x0p1 < w_side) ? IDX_W'(x0p1) : w_m1;
    y1   = (y0p1 < h_side) ? IDX_W'(y0p1) : h_m1;
  end

  always_ff @(posedge clk_i) begin
    a00_q <= bnp_pkg::ADDR_W'(32'(y0) * 32'(w_side) + 32'(x0));
    a10_q <= bnp_pkg::ADDR_W'(32'(y0) * 32'(w_side) + 32'(x1));
    a01_q <= bnp_pkg::ADDR_W'(32'(y1) * 32'(w_side) + 32'(x0));
    a11_q <= bnp_pkg::ADDR_W'(32'(y1) * 32'(w_side) + 32'(x1));
    fx3_q <= tx_q[FB-1:0];
    fy3_q <= ty_q[FB-1:0];
  end

  // ---------------- Stage 4: texel store ----------------
  bnp_pkg::texmem_wr_t mem_wr;
  logic [bnp_pkg::TEXEL_W-1:0] t00, t10, t01, t11;
  logic [FB-1:0] fx4_q, fy4_q;

  assign mem_wr.we   = wv_q[3];
  assign mem_wr.addr = widx_q[3];
  assign mem_wr.data = wdata_q[3];

  bnp_texmem u_mem_top (
    .clk_i       (clk_i),
    .wr_i        (mem_wr),
    .rd_addr_a_i (a00_q),
    .rd_addr_b_i (a10_q),
    .rd_data_a_o (t00),
    .rd_data_b_o (t10)
  );

  bnp_texmem u_mem_bot (
    .clk_i       (clk_i),
    .wr_i        (mem_wr),
    .rd_addr_a_i (a01_q),
    .rd_addr_b_i (a11_q),
    .rd_data_a_o (t01),
    .rd_data_b_o (t11)
  );

  always_ff @(posedge clk_i) begin
    fx4_q <= fx3_q;
    fy4_q <= fy3_q;
  end

  // ---------------- Stage 5: horizontal blend ----------------
  logic [3:0][H_W-1:0] top_q, bot_q;
  logic [FB-1:0]       fy5_q;
  logic [FB:0]         wx1;

  assign wx1 = ONE - (FB+1)'(fx4_q);

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      top_q[c] <= H_W'(H_W'(t00[8*c +: 8]) * H_W'(wx1) + H_W'(t10[8*c +: 8]) * H_W'(fx4_q));
      bot_q[c] <= H_W'(H_W'(t01[8*c +: 8]) * H_W'(wx1) + H_W'(t11[8*c +: 8]) * H_W'(fx4_q));
    end
    fy5_q <= fy4_q;
  end

  // ---------------- Stage 6: vertical blend ----------------
  logic [3:0][23:0] v16_q;
  logic [FB:0]      wy1;
  logic [3:0][V_W-1:0] vsum;

  assign wy1 = ONE - (FB+1)'(fy5_q);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      vsum[c] = V_W'(top_q[c]) * V_W'(wy1) + V_W'(bot_q[c]) * V_W'(fy5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      v16_q[c] <= vsum[c][(2*FB-16) +: 24];
    end
  end

  // ---------------- Stage 7: divide by 255, round ----------------
  logic [3:0][bnp_pkg::CH_W-1:0] ch7_q;
  logic [3:0][Q_W-1:0]           qprod;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qprod[c] = Q_W'(N_W'(v16_q[c]) + N_W'(127)) * Q_W'(bnp_pkg::RECIP_255);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      if (!pres_q[6]) begin
        ch7_q[c] <= bnp_pkg::CH_NEUTRAL;
      end else if (qprod[c][Q_W-1:bnp_pkg::RECIP_SHIFT + bnp_pkg::CH_W] != '0) begin
        ch7_q[c] <= '1;
      end else begin
        ch7_q[c] <= qprod[c][bnp_pkg::RECIP_SHIFT +: bnp_pkg::CH_W];
      end
    end
  end

  // ---------------- Stage 8: displacement product ----------------
  logic signed [17:0]     kx, ky;
  logic signed [PR_W-1:0] dpx_q, dpy_q;
  logic [3:0][bnp_pkg::CH_W-1:0] ch8_q;

  assign kx = $signed({1'b0, ch7_q[0], 1'b0}) - 18'sd65536;
  assign ky = $signed({1'b0, ch7_q[1], 1'b0}) - 18'sd65536;

  always_ff @(posedge clk_i) begin
    dpx_q <= PR_W'(kx) * $signed({{(PR_W-bnp_pkg::STR_W){1'b0}}, str_q});
    dpy_q <= PR_W'(ky) * $signed({{(PR_W-bnp_pkg::STR_W){1'b0}}, str_q});
    ch8_q <= ch7_q;
  end

  // ---------------- Stage 9: round, add, saturate ----------------
  logic signed [PR_W-1:0] rx, ry;
  logic signed [33:0]     sumx, sumy;
  logic signed [bnp_pkg::POS_W-1:0] mx, my;
  logic                   out_v_q;
  logic [3:0][bnp_pkg::CH_W-1:0] ch9_q;
  logic signed [bnp_pkg::POS_W-1:0] mx_q, my_q;

  always_comb begin
    rx   = dpx_q + PR_W'(32768);
    ry   = dpy_q + PR_W'(32768);
    sumx = {{2{px_q[8][31]}}, px_q[8]} + {{11{rx[PR_W-1]}}, rx[PR_W-1:16]};
    sumy = {{2{py_q[8][31]}}, py_q[8]} + {{11{ry[PR_W-1]}}, ry[PR_W-1:16]};
    if (sumx > 34'sh07FFFFFFF)       mx = 32'sh7FFFFFFF;
    else if (sumx < -34'sh080000000) mx = 32'sh80000000;
    else                             mx = sumx[31:0];
    if (sumy > 34'sh07FFFFFFF)       my = 32'sh7FFFFFFF;
    else if (sumy < -34'sh080000000) my = 32'sh80000000;
    else                             my = sumy[31:0];
  end

  // The strobe is registered at the same edge as the result data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else         out_v_q <= sv_q[8];
  end

  always_ff @(posedge clk_i) begin
    ch9_q <= ch8_q;
    mx_q  <= mx;
    my_q  <= my;
  end

  assign result_valid_o = out_v_q;
  assign noise_r_o      = ch9_q[0];
  assign noise_g_o      = ch9_q[1];
  assign noise_b_o      = ch9_q[2];
  assign noise_a_o      = ch9_q[3];
  assign moved_x_o      = mx_q;
  assign moved_y_o      = my_q;

  // ---------------- Assertions ----------------
  `BNP_ASSERT_IMP(a_result_from_sample, result_valid_o,
    $past(accept && (opcode_i == bnp_pkg::OP_SAMPLE), LAT))
  `BNP_ASSERT_IMP(a_neutral_passthrough,
    $past(accept && (opcode_i == bnp_pkg::OP_SAMPLE) && !present_q, LAT),
    result_valid_o && (moved_x_o == $past(pos_x_i, LAT)) && (moved_y_o == $past(pos_y_i, LAT)))
  `BNP_ASSERT_IMP(a_write_reaches_store, mem_wr.we,
    $past(accept && (opcode_i == bnp_pkg::OP_WRITE), WR_LAT))
  `BNP_ASSERT_NXT(a_busy_single_cycle, busy_o, !busy_o)

endmodule

>>> tb/bilinear_noise_perturb_top_tb.sv
// ----------------------------------------------------------------------------
// Bilinear noise perturb testbench
// Loads the low texels of the store that every texture size used here reads,
// then runs several register settings through the block with short directed
// position sweeps and random streams of texel writes and samples. A
// scoreboard predicts every sample result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_noise_perturb_top_tb;

  localparam int LATENCY     = 10;
  localparam int CYCLE_LIMIT = 2000000;
  // Every texture size below covers at most this many texels.
  localparam int FILL_TEXELS = 256;

  typedef logic [bnp_pkg::CFG_DATA_W-1:0] cfg_data_t;

  // One predicted sample result.
  typedef struct {
    logic [bnp_pkg::CH_W-1:0]  ch_r, ch_g, ch_b, ch_a;
    logic [bnp_pkg::POS_W-1:0] mx, my;
  } sample_t;

  // Shadow of the block: texel store, registers and pending samples.
  class noise_scoreboard;
    logic [bnp_pkg::TEXEL_W-1:0] texels [65536];
    bit                 present = 0;
    int unsigned        width = 256, height = 256;
    longint             scale = 655, strength = 32768;
    sample_t            pending [$];
    int                 errors = 0;

    function void set_reg(logic [bnp_pkg::CFG_IDX_W-1:0] idx, cfg_data_t d);
      case (idx)
        bnp_pkg::CFG_NOISE_PRESENT: present  = d[0];
        bnp_pkg::CFG_TEX_WIDTH:     width    = d[8:0];
        bnp_pkg::CFG_TEX_HEIGHT:    height   = d[8:0];
        bnp_pkg::CFG_NOISE_SCALE:   scale    = d[15:0];
        bnp_pkg::CFG_PERTURB_STR:   strength = d[19:0];
        default: ;
      endcase
    endfunction

    function int unsigned side(int unsigned s);
      if (s < 1) return 1;
      if (s > 256) return 256;
      return s;
    endfunction

    // Wrapped fraction of pos * scale in Q0.16.
    function longint wrap_frac(longint pos);
      longint prod;
      prod = pos * scale;
      return (prod & 64'hFFFF_FFFF) >> 16;
    endfunction

    function logic [15:0] blend(longint c00, longint c10, longint c01,
                                longint c11, longint fx, longint fy);
      longint one, top, bot, v, q;
      one = 65536;
      top = c00 * (one - fx) + c10 * fx;
      bot = c01 * (one - fx) + c11 * fx;
      v = top * (one - fy) + bot * fy;
      q = ((v >> 16) + 127) / 255;
      if (q > 65535) q = 65535;
      return q[15:0];
    endfunction

    // Displacement by (2s-1)*strength, rounded half up, then saturated.
    function logic [31:0] shift_pos(longint pos, longint s);
      longint k, prod, d, sum;
      k = 2 * s - 65536;
      prod = k * strength;
      d = ((prod + 32768 + (64'sd1 <<< 40)) >>> 16) - (64'sd1 <<< 24);
      sum = pos + d;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
    endfunction

    function void note_item(logic op, logic [15:0] idx, logic [31:0] rgba,
                            logic signed [31:0] px, logic signed [31:0] py);
      sample_t      e;
      longint       tx, ty, fx, fy;
      int unsigned  w, h, x0, y0, x1, y1;
      logic [31:0]  t00, t10, t01, t11;
      logic [15:0]  ch [4];
      if (op == bnp_pkg::OP_WRITE) begin
        texels[idx] = rgba;
        return;
      end
      if (!present) begin
        foreach (ch[i]) ch[i] = bnp_pkg::CH_NEUTRAL;
      end else begin
        w = side(width);
        h = side(height);
        tx = wrap_frac(px) * (w - 1);
        ty = wrap_frac(py) * (h - 1);
        fx = tx & 16'hFFFF;
        fy = ty & 16'hFFFF;
        x0 = tx >> 16;
        y0 = ty >> 16;
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        t00 = texels[16'(y0 * w + x0)];
        t10 = texels[16'(y0 * w + x1)];
        t01 = texels[16'(y1 * w + x0)];
        t11 = texels[16'(y1 * w + x1)];
        foreach (ch[i])
          ch[i] = blend(t00[8*i+:8], t10[8*i+:8], t01[8*i+:8], t11[8*i+:8], fx, fy);
      end
      e.ch_r = ch[0];
      e.ch_g = ch[1];
      e.ch_b = ch[2];
      e.ch_a = ch[3];
      e.mx = shift_pos(px, ch[0]);
      e.my = shift_pos(py, ch[1]);
      pending.push_back(e);
    endfunction

    function void check_result(sample_t got);
      sample_t e;
      if (pending.size() == 0) begin
        $error("result with no sample pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ch_r !== e.ch_r) begin
        $error("noise_r expected %h got %h", e.ch_r, got.ch_r); errors++;
      end
      if (got.ch_g !== e.ch_g) begin
        $error("noise_g expected %h got %h", e.ch_g, got.ch_g); errors++;
      end
      if (got.ch_b !== e.ch_b) begin
        $error("noise_b expected %h got %h", e.ch_b, got.ch_b); errors++;
      end
      if (got.ch_a !== e.ch_a) begin
        $error("noise_a expected %h got %h", e.ch_a, got.ch_a); errors++;
      end
      if (got.mx !== e.mx) begin
        $error("moved_x expected %h got %h", e.mx, got.mx); errors++;
      end
      if (got.my !== e.my) begin
        $error("moved_y expected %h got %h", e.my, got.my); errors++;
      end
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              start_i = 1'b0;
  logic                              busy_o;
  logic                              opcode_i = bnp_pkg::OP_WRITE;
  logic [bnp_pkg::ADDR_W-1:0]        texel_index_i = '0;
  logic [bnp_pkg::TEXEL_W-1:0]       texel_rgba_i = '0;
  logic signed [bnp_pkg::POS_W-1:0]  pos_x_i = '0;
  logic signed [bnp_pkg::POS_W-1:0]  pos_y_i = '0;
  logic                              cfg_we_i = 1'b0;
  logic [bnp_pkg::CFG_IDX_W-1:0]     cfg_idx_i = '0;
  cfg_data_t                         cfg_data_i = '0;
  logic                              result_valid_o;
  logic [bnp_pkg::CH_W-1:0]          noise_r_o, noise_g_o, noise_b_o, noise_a_o;
  logic signed [bnp_pkg::POS_W-1:0]  moved_x_o, moved_y_o;

  noise_scoreboard sb = new();
  int              cycles = 0;
  bit              idling_on = 1;

  bilinear_noise_perturb_top uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver cannot stall, so every strobed result is checked on the edge
  // that ends its cycle.
  always @(posedge clk_i) begin
    sample_t got;
    if (rst_ni && result_valid_o) begin
      got.ch_r = noise_r_o;
      got.ch_g = noise_g_o;
      got.ch_b = noise_b_o;
      got.ch_a = noise_a_o;
      got.mx = moved_x_o;
      got.my = moved_y_o;
      sb.check_result(got);
    end
  end

  // Presents one item from a falling edge and holds it until an edge takes
  // it with busy low. Start stays high; only idle gaps and drain lower it.
  task automatic send_item(logic op, logic [15:0] idx, logic [31:0] rgba,
                           logic [31:0] px, logic [31:0] py);
    @(negedge clk_i);
    start_i       <= 1'b1;
    opcode_i      <= op;
    texel_index_i <= idx;
    texel_rgba_i  <= rgba;
    pos_x_i       <= px;
    pos_y_i       <= py;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(op, idx, rgba, px, py);
    // A one-cycle gap after about a fifth of the items keeps start low about a
    // sixth of the time.
    if (idling_on && $urandom_range(99) < 20) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Lowers start and lets the pipeline drain completely, including any
  // texel writes that are still travelling toward the store.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bnp_pkg::CFG_IDX_W-1:0] idx, cfg_data_t d);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic setup(bit pres, int w, int h, int sc, int st);
    drain();
    write_reg(bnp_pkg::CFG_NOISE_PRESENT, cfg_data_t'(pres));
    write_reg(bnp_pkg::CFG_TEX_WIDTH, cfg_data_t'(w));
    write_reg(bnp_pkg::CFG_TEX_HEIGHT, cfg_data_t'(h));
    write_reg(bnp_pkg::CFG_NOISE_SCALE, cfg_data_t'(sc));
    write_reg(bnp_pkg::CFG_PERTURB_STR, cfg_data_t'(st));
  endtask

  // Positions favor the extremes and small values near zero.
  function automatic logic [31:0] pick_pos();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(65535)) - 32'd32768;
      default: return $urandom;
    endcase
  endfunction

  // A random stream: about a third texel writes anywhere in the store and
  // the rest samples; unused fields get random values too.
  task automatic random_run(int n, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      if ($urandom_range(2) == 0)
        send_item(bnp_pkg::OP_WRITE, 16'($urandom), $urandom, $urandom, $urandom);
      else
        send_item(bnp_pkg::OP_SAMPLE, 16'($urandom), $urandom, pick_pos(), pick_pos());
    end
  endtask

  initial begin
    logic [31:0] corners [4];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Neutral sampling with the reset registers, before any texture exists.
    for (int i = 0; i < 4; i++)
      send_item(bnp_pkg::OP_SAMPLE, 16'($urandom), $urandom, corners[i], corners[3-i]);

    // Fill every texel that the texture sizes below can reach, back to back.
    idling_on = 0;
    for (int a = 0; a < FILL_TEXELS; a++)
      send_item(bnp_pkg::OP_WRITE, 16'(a), $urandom, $urandom, $urandom);
    idling_on = 1;

    // Square texture at the reset scale, with a directed corner sweep,
    // a full-white texel at the origin and a rewrite of it.
    setup(1, 16, 16, 655, 32768);
    send_item(bnp_pkg::OP_WRITE, 16'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_item(bnp_pkg::OP_SAMPLE, 16'($urandom), $urandom, corners[i], corners[j]);
    send_item(bnp_pkg::OP_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_item(bnp_pkg::OP_WRITE, 16'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bnp_pkg::OP_SAMPLE, 16'd0, 32'd0, 32'd0, 32'd0);
    random_run(150, 60);

    // Single-texel texture, largest scale and strength.
    setup(1, 1, 1, 65535, 20'hFFFFF);
    random_run(120, -1);

    // Zero width and oversized height, no scale and no displacement.
    setup(1, 0, 511, 0, 0);
    random_run(120, -1);

    // Odd sizes with no idling at all.
    setup(1, 17, 15, 40000, 300000);
    idling_on = 0;
    random_run(160, -1);
    idling_on = 1;

    // Oversized width clamped to MAX_SIDE, a single row.
    setup(1, 300, 1, 65535, 1);
    random_run(120, -1);

    // Random settings.
    for (int p = 0; p < 2; p++) begin
      setup(1, $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(65535),
            $urandom_range(20'hFFFFF));
      random_run(100, -1);
    end

    // Texture switched off again with full strength.
    setup(0, 300, 0, 12345, 20'hFFFFF);
    random_run(100, -1);

    drain();
    repeat (LATENCY) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
